// File: hdl/affine_matrix_inverse_macros.svh
// assertion macros shared by the affine inverse rtl
`ifndef AFFINE_MATRIX_INVERSE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AMI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define AMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ami_pkg.sv
// shared widths and word types of the affine inverse
`default_nettype none

package ami_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WW = 32;                       // field width
	localparam int TW = 31;                       // threshold width
	localparam int CW = 2 * WW;                   // cofactor width
	localparam int PW = WW + CW;                  // row times cofactor product
	localparam int DW = PW + 2;                   // determinant and translation sums
	localparam int QB = WW + 1;                   // quotient bits incl. rounding bit
	localparam int NLW = CW + 2 * FRAC_BITS + 1;  // doubled linear numerator
	localparam int NTW = DW + FRAC_BITS + 1;      // doubled translation numerator
	localparam int LANES = 12;
	localparam int LIN = 9;

	typedef logic signed [WW-1:0] word_t;

	typedef struct packed {
		word_t a00; word_t a01; word_t a02;
		word_t a10; word_t a11; word_t a12;
		word_t a20; word_t a21; word_t a22;
		word_t t0;  word_t t1;  word_t t2;
	} in_word_t;

	typedef struct packed {
		word_t inv_a00; word_t inv_a01; word_t inv_a02;
		word_t inv_a10; word_t inv_a11; word_t inv_a12;
		word_t inv_a20; word_t inv_a21; word_t inv_a22;
		word_t inv_t0;  word_t inv_t1;  word_t inv_t2;
	} out_word_t;

	// one division job: doubled numerator split at the quotient bits
	typedef struct packed {
		logic [DW-1:0] hi;
		logic [QB-1:0] lo;
		logic [DW-1:0] dmag;
		logic          neg;
		logic          sing;
	} lane_in_t;

endpackage

`default_nettype wire

// File: hdl/ami_in_if.sv
// transform input channel
`default_nettype none

interface ami_in_if;
	logic valid;
	logic ready;
	ami_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ami_out_if.sv
// inverse result channel
`default_nettype none

interface ami_out_if;
	logic valid;
	logic ready;
	ami_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ami_front.sv
// cofactor, determinant and translation numerator pipeline
`default_nettype none

module ami_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  ami_pkg::in_word_t        in_word,
	input  logic [ami_pkg::TW-1:0]   thr,
	output logic                     out_valid,
	output ami_pkg::lane_in_t        lanes [ami_pkg::LANES]
);

	localparam int WW = ami_pkg::WW;
	localparam int CW = ami_pkg::CW;
	localparam int PW = ami_pkg::PW;
	localparam int DW = ami_pkg::DW;
	localparam int QB = ami_pkg::QB;
	localparam int NLW = ami_pkg::NLW;
	localparam int NTW = ami_pkg::NTW;
	localparam int ZL = 2 * ami_pkg::FRAC_BITS + 1;
	localparam int ZT = ami_pkg::FRAC_BITS + 1;
	localparam int SHT = 2 * ami_pkg::FRAC_BITS;

	ami_pkg::word_t m [3][3];
	ami_pkg::word_t tr [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [CW-1:0] pa_s1 [3][3];
	logic signed [CW-1:0] pb_s1 [3][3];
	ami_pkg::word_t       r0_s1 [3];
	ami_pkg::word_t       t_s1 [3];

	logic signed [CW-1:0] cof_s2 [3][3];
	ami_pkg::word_t       r0_s2 [3];
	ami_pkg::word_t       t_s2 [3];

	logic signed [CW:0]   dlo_s3 [3];
	logic signed [CW-1:0] dhi_s3 [3];
	logic signed [CW:0]   tlo_s3 [3][3];
	logic signed [CW-1:0] thi_s3 [3][3];
	logic signed [CW-1:0] cof_s3 [3][3];

	logic signed [PW-1:0] dp_s4 [3];
	logic signed [PW-1:0] tp_s4 [3][3];
	logic signed [CW-1:0] cof_s4 [3][3];

	logic signed [DW-1:0] det_s5;
	logic signed [DW-1:0] acc_s5 [3];
	logic signed [CW-1:0] cof_s5 [3][3];

	logic [DW-1:0] dmag_s6;
	logic          dneg_s6;
	logic [CW-1:0] cmag_s6 [3][3];
	logic          cneg_s6 [3][3];
	logic [DW-1:0] amag_s6 [3];
	logic          aneg_s6 [3];

	logic [DW-1:0] dmag_s7;
	logic          dneg_s7;
	logic          sing_s7;
	logic [CW-1:0] cmag_s7 [3][3];
	logic          cneg_s7 [3][3];
	logic [DW-1:0] amag_s7 [3];
	logic          aneg_s7 [3];

	// unpack the word into rows
	assign m[0][0] = in_word.a00;
	assign m[0][1] = in_word.a01;
	assign m[0][2] = in_word.a02;
	assign m[1][0] = in_word.a10;
	assign m[1][1] = in_word.a11;
	assign m[1][2] = in_word.a12;
	assign m[2][0] = in_word.a20;
	assign m[2][1] = in_word.a21;
	assign m[2][2] = in_word.a22;
	assign tr[0] = in_word.t0;
	assign tr[1] = in_word.t1;
	assign tr[2] = in_word.t2;

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: the two minor products of each cofactor
	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			localparam int I1 = (gi + 1) % 3;
			localparam int I2 = (gi + 2) % 3;
			localparam int J1 = (gj + 1) % 3;
			localparam int J2 = (gj + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[gi][gj] <= m[I1][J1] * m[I2][J2];
					pb_s1[gi][gj] <= m[I1][J2] * m[I2][J1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r0_s1[gi] <= m[0][gi];
				t_s1[gi] <= tr[gi];
			end
		end
	end

	// stage 2: cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cof_s2[i][j] <= pa_s1[i][j] - pb_s1[i][j];
				end
				r0_s2[i] <= r0_s1[i];
				t_s2[i] <= t_s1[i];
			end
		end
	end

	// stage 3: 32x32 partial products of row and translation against cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dlo_s3[k] <= r0_s2[k] * $signed({1'b0, cof_s2[0][k][WW-1:0]});
				dhi_s3[k] <= r0_s2[k] * $signed(cof_s2[0][k][CW-1:WW]);
				for (int i = 0; i < 3; i++) begin
					tlo_s3[k][i] <= t_s2[i] * $signed({1'b0, cof_s2[k][i][WW-1:0]});
					thi_s3[k][i] <= t_s2[i] * $signed(cof_s2[k][i][CW-1:WW]);
					cof_s3[k][i] <= cof_s2[k][i];
				end
			end
		end
	end

	// stage 4: join partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dp_s4[k] <= {dhi_s3[k], WW'(0)} + PW'(dlo_s3[k]);
				for (int i = 0; i < 3; i++) begin
					tp_s4[k][i] <= {thi_s3[k][i], WW'(0)} + PW'(tlo_s3[k][i]);
					cof_s4[k][i] <= cof_s3[k][i];
				end
			end
		end
	end

	// stage 5: determinant and translation numerators
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= DW'(dp_s4[0]) + DW'(dp_s4[1]) + DW'(dp_s4[2]);
			for (int k = 0; k < 3; k++) begin
				acc_s5[k] <= DW'(tp_s4[k][0]) + DW'(tp_s4[k][1]) + DW'(tp_s4[k][2]);
				for (int i = 0; i < 3; i++) begin
					cof_s5[k][i] <= cof_s4[k][i];
				end
			end
		end
	end

	// stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			for (int k = 0; k < 3; k++) begin
				aneg_s6[k] <= acc_s5[k][DW-1];
				amag_s6[k] <= acc_s5[k][DW-1] ? DW'(-acc_s5[k]) : DW'(acc_s5[k]);
				for (int i = 0; i < 3; i++) begin
					cneg_s6[k][i] <= cof_s5[k][i][CW-1];
					cmag_s6[k][i] <= cof_s5[k][i][CW-1] ? CW'(-cof_s5[k][i])
						: CW'(cof_s5[k][i]);
				end
			end
		end
	end

	// stage 7: singular test against the threshold
	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s7 <= dneg_s6;
			dmag_s7 <= dmag_s6;
			sing_s7 <= (dmag_s6 == '0) || (dmag_s6 < (DW'(thr) << SHT));
			for (int k = 0; k < 3; k++) begin
				aneg_s7[k] <= aneg_s6[k];
				amag_s7[k] <= amag_s6[k];
				for (int i = 0; i < 3; i++) begin
					cneg_s7[k][i] <= cneg_s6[k][i];
					cmag_s7[k][i] <= cmag_s6[k][i];
				end
			end
		end
	end

	assign out_valid = v_s7;

	// division jobs: linear part takes transposed cofactors
	for (genvar gr = 0; gr < 3; gr++) begin : g_lin_r
		for (genvar gc = 0; gc < 3; gc++) begin : g_lin_c
			logic [NLW-1:0] two_n;
			assign two_n = {cmag_s7[gc][gr], ZL'(0)};
			assign lanes[gr*3+gc].hi = DW'(two_n >> QB);
			assign lanes[gr*3+gc].lo = two_n[QB-1:0];
			assign lanes[gr*3+gc].dmag = dmag_s7;
			assign lanes[gr*3+gc].neg = cneg_s7[gc][gr] ^ dneg_s7;
			assign lanes[gr*3+gc].sing = sing_s7;
		end
	end

	// translation jobs: numerator is minus the accumulated sum
	for (genvar gj = 0; gj < 3; gj++) begin : g_tr
		logic [NTW-1:0] two_n;
		assign two_n = {amag_s7[gj], ZT'(0)};
		assign lanes[ami_pkg::LIN+gj].hi = DW'(two_n >> QB);
		assign lanes[ami_pkg::LIN+gj].lo = two_n[QB-1:0];
		assign lanes[ami_pkg::LIN+gj].dmag = dmag_s7;
		assign lanes[ami_pkg::LIN+gj].neg = !aneg_s7[gj] ^ dneg_s7;
		assign lanes[ami_pkg::LIN+gj].sing = sing_s7;
	end

endmodule

`default_nettype wire

// File: hdl/ami_lane.sv
// pipelined restoring divider with rounding and saturation
`default_nettype none
`include "affine_matrix_inverse_macros.svh"

module ami_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ami_pkg::lane_in_t lane_in,
	output logic              out_valid,
	output ami_pkg::word_t    out_word
);

	localparam int WW = ami_pkg::WW;
	localparam int DW = ami_pkg::DW;
	localparam int QB = ami_pkg::QB;
	localparam logic [QB-1:0] LIM_NEG = QB'(1) << (WW - 1);
	localparam logic [QB-1:0] LIM_POS = LIM_NEG - QB'(1);

	typedef struct packed {
		logic [DW-1:0] r;
		logic [QB-1:0] l;
		logic [QB-1:0] q;
		logic [DW-1:0] d;
		logic          neg;
		logic          ovf;
		logic          sing;
	} step_t;

	step_t          div_s [QB+1];
	logic           dv_s [QB+1];
	ami_pkg::word_t fin_word_s;
	logic           fin_v_s;

	logic [QB:0]    q_inc;
	logic [QB-1:0]  q_rnd;
	logic [QB-1:0]  lim;
	logic [QB-1:0]  mag;
	ami_pkg::word_t res;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				dv_s[k] <= 1'b0;
			end
			fin_v_s <= 1'b0;
		end else if (en) begin
			dv_s[0] <= in_valid;
			for (int k = 1; k <= QB; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
			fin_v_s <= dv_s[QB];
		end
	end

	// entry: overflow when the quotient cannot fit
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].r <= lane_in.hi;
			div_s[0].l <= lane_in.lo;
			div_s[0].q <= '0;
			div_s[0].d <= lane_in.dmag;
			div_s[0].neg <= lane_in.neg;
			div_s[0].ovf <= lane_in.hi >= lane_in.dmag;
			div_s[0].sing <= lane_in.sing;
		end
	end

	// one quotient bit per stage
	for (genvar gk = 1; gk <= QB; gk++) begin : g_step
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          ge;
		assign trial = {div_s[gk-1].r, div_s[gk-1].l[QB-1]};
		assign diff = {1'b0, trial} - {2'b00, div_s[gk-1].d};
		assign ge = !diff[DW+1];
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[gk].r <= ge ? diff[DW-1:0] : trial[DW-1:0];
				div_s[gk].l <= div_s[gk-1].l << 1;
				div_s[gk].q <= {div_s[gk-1].q[QB-2:0], ge};
				div_s[gk].d <= div_s[gk-1].d;
				div_s[gk].neg <= div_s[gk-1].neg;
				div_s[gk].ovf <= div_s[gk-1].ovf;
				div_s[gk].sing <= div_s[gk-1].sing;
			end
		end
	end

	// round half away from zero, saturate, apply sign
	always_comb begin
		q_inc = {1'b0, div_s[QB].q} + (QB+1)'(1);
		q_rnd = q_inc[QB:1];
		lim = div_s[QB].neg ? LIM_NEG : LIM_POS;
		mag = (div_s[QB].ovf || (q_rnd > lim)) ? lim : q_rnd;
		res = div_s[QB].neg ? -mag[WW-1:0] : mag[WW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_word_s <= div_s[QB].sing ? '0 : res;
		end
	end

	assign out_valid = fin_v_s;
	assign out_word = fin_word_s;

	`AMI_ASSERT_SAME(a_rem_below_div, clk, arst_n,
		dv_s[QB] && !div_s[QB].ovf && !div_s[QB].sing, div_s[QB].r < div_s[QB].d,
		"remainder not below divisor")
	`AMI_ASSERT_NEXT(a_sing_zero, clk, arst_n,
		en && dv_s[QB] && div_s[QB].sing, fin_word_s == '0,
		"singular job gave nonzero word")
	`AMI_ASSERT_NEXT(a_ovf_sat, clk, arst_n,
		en && dv_s[QB] && div_s[QB].ovf && !div_s[QB].sing,
		(fin_word_s == 32'sh7fffffff) || (fin_word_s == 32'sh80000000),
		"overflow job not saturated")

endmodule

`default_nettype wire

// File: hdl/affine_matrix_inverse.sv
// Affine transform inverse, top level.
// One transform word enters on xform (3x3 linear part a00..a22 and translation
// t0..t2, signed fixed point) and one word leaves on inverse: the inverse
// linear part and translation, rounded to nearest with ties away from zero and
// saturated to 32 bits. When the determinant magnitude is below the threshold
// register, or zero, every field of the word is zero.
// cfg_we with cfg_wdata loads the threshold; write it only while no word is in
// flight. Reset loads a threshold of one step and empties the pipeline.
// A word accepted on xform is presented on inverse after seven stages of
// cofactor, determinant, magnitude and singular-test logic, one overflow
// check, 33 divider stages (one quotient bit each, twelve dividers in
// parallel), a rounding and saturation stage and the output register.
// Throughput: one word per cycle while the receiver takes words.
// A stalled output is backed by one skid register: the pipeline keeps moving
// until the next word reaches the output and goes into the skid; xform.ready
// then drops until the skid drains, and no word is lost or repeated.
`default_nettype none
`include "affine_matrix_inverse_macros.svh"

module affine_matrix_inverse (
	input  logic                   clk,
	input  logic                   arst_n,
	ami_in_if.sink                 xform,
	ami_out_if.source              inverse,
	input  logic                   cfg_we,
	input  logic [ami_pkg::TW-1:0] cfg_wdata
);

	localparam int LANES = ami_pkg::LANES;

	logic [ami_pkg::TW-1:0] thr_q;
	logic                   adv;
	logic                   front_v;
	ami_pkg::lane_in_t      jobs [LANES];
	logic [LANES-1:0]       lane_v;
	ami_pkg::word_t         lane_w [LANES];
	ami_pkg::out_word_t     res;
	ami_pkg::out_word_t     out_q;
	ami_pkg::out_word_t     skid_q;
	logic                   out_v_q;
	logic                   skid_v_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ami_pkg::TW'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// the whole pipeline moves while the skid is empty
	assign adv = !skid_v_q;
	assign xform.ready = adv;

	ami_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (xform.valid),
		.in_word   (xform.data),
		.thr       (thr_q),
		.out_valid (front_v),
		.lanes     (jobs)
	);

	for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
		ami_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (front_v),
			.lane_in   (jobs[gl]),
			.out_valid (lane_v[gl]),
			.out_word  (lane_w[gl])
		);
	end

	assign res.inv_a00 = lane_w[0];
	assign res.inv_a01 = lane_w[1];
	assign res.inv_a02 = lane_w[2];
	assign res.inv_a10 = lane_w[3];
	assign res.inv_a11 = lane_w[4];
	assign res.inv_a12 = lane_w[5];
	assign res.inv_a20 = lane_w[6];
	assign res.inv_a21 = lane_w[7];
	assign res.inv_a22 = lane_w[8];
	assign res.inv_t0 = lane_w[9];
	assign res.inv_t1 = lane_w[10];
	assign res.inv_t2 = lane_w[11];

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (adv && lane_v[0]) begin
			if (out_v_q && !inverse.ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_v_q && inverse.ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (adv && lane_v[0]) begin
			if (out_v_q && !inverse.ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (out_v_q && inverse.ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign inverse.valid = out_v_q;
	assign inverse.data = out_q;

	`AMI_ASSERT_SAME(a_lanes_aligned, clk, arst_n,
		1'b1, (lane_v == '0) || (lane_v == '1),
		"divider lanes out of step")
	`AMI_ASSERT_SAME(a_skid_behind_out, clk, arst_n,
		skid_v_q, out_v_q,
		"skid holds a word while output is empty")
	`AMI_ASSERT_NEXT(a_skid_catch, clk, arst_n,
		!skid_v_q && lane_v[0] && out_v_q && !inverse.ready, skid_v_q,
		"stalled word not caught by skid")

endmodule

`default_nettype wire
